// ===== rtl/k_way_min_merge_assert.svh =====
// ----------------------------------------------------------------------------
// k_way_min_merge assertion macros
// Short forms for clocked properties with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MIN_MERGE_ASSERT_SVH
`define K_WAY_MIN_MERGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define KWM_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define KWM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared widths, the head candidate type and the pairwise minimum select.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam int DATA_W   = 32;
  localparam int WAY_W    = 3;
  localparam int CNT_W    = 4;
  localparam int MAX_WAYS = 8;

  localparam logic [CNT_W-1:0] WAY_COUNT_RST = CNT_W'(8);
  localparam logic [CNT_W-1:0] WAY_COUNT_MIN = CNT_W'(2);

  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
    logic [WAY_W-1:0]         idx;
  } head_cand_t;

  // a always holds the lower ways, so it wins a tie
  function automatic head_cand_t kwm_pick(input head_cand_t a, input head_cand_t b);
    head_cand_t res;
    if (a.vld && (!b.vld || (a.val <= b.val))) begin
      res = a;
    end else begin
      res = b;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/k_way_min_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_min_merge
// Merge of up to eight sorted runs of signed 32-bit values by minimum select.
// ----------------------------------------------------------------------------
// One item is taken per clock when the result side keeps up. An accepted item
// sits in an input register, where the head table is updated and a comparator
// tree over all heads picks the smallest valid one; the result is written to the
// output register as its item leaves the input register, which holds while an
// untaken result blocks it. The tree depth, ceil log2 of min(WAYS, 8), sets the
// clock. Fill items go to ways 0, 1, 2 and so on in turn whatever their way field;
// the last one releases the first minimum. Afterwards each item must name the
// way of the last result; items for other ways are dropped without a result.
// With no valid head left an end marker (value 0, way 0, end flag set) is sent
// and the block starts a new fill. way_count is clamped to 2..min(WAYS, 8) and
// may only be written while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_min_merge
  import kwm_pkg::*;
#(
  parameter int WAYS = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr_en,
  input  wire        [CNT_W-1:0]         cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire        [WAY_W-1:0]         in_way,
  input  wire signed [DATA_W-1:0]        in_value,
  input  wire                            in_exhausted,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [DATA_W-1:0]       out_merged_value,
  output logic       [WAY_W-1:0]         out_source_way,
  output logic                           out_end_of_merge
);

  localparam int NW = (WAYS < MAX_WAYS) ? WAYS : MAX_WAYS;
  localparam int WI = $clog2(NW);
  localparam int NP = 1 << WI;
  localparam logic [CNT_W-1:0] NW_CNT = CNT_W'(NW);

  localparam logic PH_FILL   = 1'b0;
  localparam logic PH_REFILL = 1'b1;

  // input register
  logic                     s1_valid_r;
  logic [WAY_W-1:0]         s1_way_r;
  logic signed [DATA_W-1:0] s1_value_r;
  logic                     s1_exh_r;

  // merge state
  logic                     phase_r, phase_nxt;
  logic [CNT_W-1:0]         fill_cnt_r, fill_cnt_nxt;
  logic [WAY_W-1:0]         refill_way_r, refill_way_nxt;
  logic [CNT_W-1:0]         way_count_r;
  logic signed [DATA_W-1:0] head_val_r [NW];
  logic [NW-1:0]            head_vld_r, head_vld_nxt;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r, res_value;
  logic [WAY_W-1:0]         out_way_r, res_way;
  logic                     out_eom_r, res_eom;

  logic                     s1_advance;
  logic                     emit;
  logic                     wr_en;
  logic [WI-1:0]            wr_idx;
  logic [CNT_W-1:0]         eff_ways;
  logic [CNT_W-1:0]         fill_inc;
  logic signed [DATA_W-1:0] upd_val [NW];
  logic [NW-1:0]            upd_vld;
  head_cand_t               tree [2*NP-1];

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_source_way   = out_way_r;
  assign out_end_of_merge = out_eom_r;

  // clamp the programmed way count
  always_comb begin
    if (way_count_r < WAY_COUNT_MIN) begin
      eff_ways = WAY_COUNT_MIN;
    end else if (way_count_r > NW_CNT) begin
      eff_ways = NW_CNT;
    end else begin
      eff_ways = way_count_r;
    end
  end

  assign fill_inc = fill_cnt_r + CNT_W'(1);

  // head table write for the item in the input register
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = '0;
    emit   = 1'b0;
    if (phase_r == PH_REFILL) begin
      wr_idx = s1_way_r[WI-1:0];
      if ((s1_way_r == refill_way_r) && ({1'b0, s1_way_r} < NW_CNT)) begin
        wr_en = 1'b1;
        emit  = 1'b1;
      end
    end else begin
      wr_idx = fill_cnt_r[WI-1:0];
      wr_en  = (fill_cnt_r < NW_CNT);
      emit   = (fill_inc >= eff_ways);
    end
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      if (wr_en && (wr_idx == WI'(i))) begin
        upd_val[i] = s1_exh_r ? head_val_r[i] : s1_value_r;
        upd_vld[i] = !s1_exh_r;
      end else begin
        upd_val[i] = head_val_r[i];
        upd_vld[i] = head_vld_r[i];
      end
    end
  end

  // minimum tree over the updated heads, leaves at NP-1 and up
  for (genvar g = 0; g < NP; g++) begin : g_leaf
    if (g < NW) begin : g_used
      assign tree[NP-1+g] = '{vld: upd_vld[g], val: upd_val[g], idx: WAY_W'(g)};
    end else begin : g_pad
      assign tree[NP-1+g] = '{vld: 1'b0, val: '0, idx: '0};
    end
  end

  for (genvar n = 0; n < NP-1; n++) begin : g_node
    assign tree[n] = kwm_pick(tree[2*n+1], tree[2*n+2]);
  end

  // next state and result
  always_comb begin
    phase_nxt      = phase_r;
    fill_cnt_nxt   = fill_cnt_r;
    refill_way_nxt = refill_way_r;
    head_vld_nxt   = upd_vld;
    res_value      = tree[0].val;
    res_way        = tree[0].idx;
    res_eom        = 1'b0;
    if (phase_r != PH_REFILL) begin
      phase_nxt    = PH_FILL;
      fill_cnt_nxt = emit ? '0 : fill_inc;
    end
    if (emit) begin
      if (tree[0].vld) begin
        phase_nxt      = PH_REFILL;
        refill_way_nxt = tree[0].idx;
      end else begin
        // end of merge: drop every head and restart the fill
        phase_nxt      = PH_FILL;
        fill_cnt_nxt   = '0;
        refill_way_nxt = '0;
        head_vld_nxt   = '0;
        res_value      = '0;
        res_way        = '0;
        res_eom        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_FILL;
      fill_cnt_r   <= '0;
      refill_way_r <= '0;
      head_vld_r   <= '0;
      way_count_r  <= WAY_COUNT_RST;
    end else begin
      if (cfg_wr_en) begin
        way_count_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        phase_r      <= phase_nxt;
        fill_cnt_r   <= fill_cnt_nxt;
        refill_way_r <= refill_way_nxt;
        head_vld_r   <= head_vld_nxt;
      end
      if (s1_advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_way_r   <= in_way;
      s1_value_r <= in_value;
      s1_exh_r   <= in_exhausted;
    end
    if (s1_advance) begin
      for (int i = 0; i < NW; i++) begin
        head_val_r[i] <= upd_val[i];
      end
    end
    if (s1_advance && emit) begin
      out_value_r <= res_value;
      out_way_r   <= res_way;
      out_eom_r   <= res_eom;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kwm_checker.sv =====
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks on the result channel of k_way_min_merge.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_way_min_merge_assert.svh"

module kwm_checker
  import kwm_pkg::*;
#(
  parameter int WAYS = 8
) (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire signed [DATA_W-1:0] out_merged_value,
  input wire        [WAY_W-1:0]  out_source_way,
  input wire                     out_end_of_merge
);

  localparam int NW = (WAYS < MAX_WAYS) ? WAYS : MAX_WAYS;
  localparam logic [CNT_W-1:0] NW_CNT = CNT_W'(NW);

  // hold a result until it is taken
  `KWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_merged_value) && $stable(out_source_way)
    && $stable(out_end_of_merge), "result changed while stalled")

  `KWM_ASSERT_SAME(a_eom_zero, clk, rst_n, out_valid && out_end_of_merge,
    (out_merged_value == '0) && (out_source_way == '0), "end marker carries data")

  `KWM_ASSERT_SAME(a_way_range, clk, rst_n, out_valid && !out_end_of_merge,
    {1'b0, out_source_way} < NW_CNT, "source way beyond the way count")

endmodule

bind k_way_min_merge kwm_checker #(.WAYS(WAYS)) u_kwm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_merged_value (out_merged_value),
  .out_source_way   (out_source_way),
  .out_end_of_merge (out_end_of_merge)
);

`default_nettype wire
